@@ rtl/grid_ray_cast_dda_defines.svh @@
// Assertion macros for the grid ray caster.
`ifndef GRID_RAY_CAST_DDA_DEFINES_SVH
`define GRID_RAY_CAST_DDA_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during rst
`define GRCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grcd assertion failed");
// next-cycle implication
`define GRCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grcd assertion failed");
`else
`define GRCD_ASSERT_IMP(lbl, ante, cons)
`define GRCD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/grcd_pkg.sv @@
// Shared constants for the grid ray caster.
package grcd_pkg;
  localparam int MAP_DIM   = 64;
  localparam int MAP_BITS  = $clog2(MAP_DIM);
  localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
  localparam int TILE_BITS = 8;
  localparam logic [7:0] TILE_MASK = (TILE_BITS >= 8) ? 8'hFF : 8'((1 << TILE_BITS) - 1);

  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [19:0] MAX20 = 20'hFFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_TILE_SHIFT = 2'd0;
  localparam logic [1:0] REG_MAP_COLS   = 2'd1;
  localparam logic [1:0] REG_MAP_ROWS   = 2'd2;
  localparam logic [1:0] REG_MAX_DIST   = 2'd3;

  localparam logic [3:0]  RST_TILE_SHIFT = 4'd6;
  localparam logic [6:0]  RST_MAP_COLS   = 7'd64;
  localparam logic [6:0]  RST_MAP_ROWS   = 7'd64;
  localparam logic [19:0] RST_MAX_DIST   = 20'd256000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;
endpackage

@@ rtl/grcd_intf.sv @@
// Input and result channel interfaces of the grid ray caster.
interface grcd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  tile_col;
  logic [5:0]  tile_row;
  logic [7:0]  tile_value;
  logic [19:0] start_x;
  logic [19:0] start_y;
  logic [19:0] target_x;
  logic [19:0] target_y;
  modport source (output valid, mode, tile_col, tile_row, tile_value, start_x, start_y,
                  target_x, target_y, input ready);
  modport sink (input valid, mode, tile_col, tile_row, tile_value, start_x, start_y,
                target_x, target_y, output ready);
endinterface

interface grcd_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        hit_side;
  logic [7:0]  hit_tile;
  logic [19:0] ray_distance;
  logic [19:0] hit_x;
  logic [19:0] hit_y;
  modport source (output valid, hit, hit_side, hit_tile, ray_distance, hit_x, hit_y,
                  input ready);
  modport sink (input valid, hit, hit_side, hit_tile, ray_distance, hit_x, hit_y,
                output ready);
endinterface

@@ rtl/grid_ray_cast_dda.sv @@
// Grid ray caster: tile map store plus DDA walk engine.
//
// in_ch carries one item per transfer. mode 0 writes one tile of the map and
// yields no result. mode 1 casts a ray from start to target direction and
// yields exactly one result transfer on out_ch (hit, side, tile, distance,
// collision point). in_ch.ready is high only while the engine is idle, so
// one item is in work at a time. A cast squares both axis deltas, takes the
// square root, then divides for the step length of each nonzero axis. Each
// walked cell is tested, stepped and probed, and a cell on the map also has
// its tile-memory read checked. On a hit, a multiply and a division for each
// axis give the collision point. The walked cell count, set by max_distance
// over the step lengths, dominates; one shared radix-2 divider serves every
// division, and the tile memory has a registered read. A zero direction
// goes straight to the result.
// Results sit in an output register; a stalled receiver holds the engine in
// its final state only, and the next item is taken once the result is
// registered. Reset (rst, synchronous) clears control state and config
// registers to their defaults; map contents stay undefined until written.
// The APB port writes config registers at byte address 4*index; pready is
// always high.
module grid_ray_cast_dda (
  input  logic        clk,
  input  logic        rst,
  grcd_in_if.sink     in_ch,
  grcd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "grid_ray_cast_dda_defines.svh"

  localparam int AW = 2 * grcd_pkg::MAP_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_ROOT_INIT, S_ROOT, S_DIVX, S_DIVY, S_DIV, S_EDGE,
    S_WALK_TEST, S_WALK_STEP, S_WALK_PROBE, S_WALK_CHECK, S_PX_MUL, S_PX_DIV,
    S_PY_MUL, S_PY_DIV, S_DONE
  } state_t;

  typedef enum logic [1:0] {DT_SX, DT_SY, DT_PX, DT_PY} div_tgt_t;

  // ---------------- configuration ----------------
  logic [3:0]  tile_shift;
  logic [6:0]  map_columns;
  logic [6:0]  map_rows_used;
  logic [19:0] max_distance;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_shift    <= grcd_pkg::RST_TILE_SHIFT;
      map_columns   <= grcd_pkg::RST_MAP_COLS;
      map_rows_used <= grcd_pkg::RST_MAP_ROWS;
      max_distance  <= grcd_pkg::RST_MAX_DIST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        grcd_pkg::REG_TILE_SHIFT: tile_shift    <= pwdata[3:0];
        grcd_pkg::REG_MAP_COLS:   map_columns   <= pwdata[6:0];
        grcd_pkg::REG_MAP_ROWS:   map_rows_used <= pwdata[6:0];
        grcd_pkg::REG_MAX_DIST:   max_distance  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      grcd_pkg::REG_TILE_SHIFT: prdata = {28'd0, tile_shift};
      grcd_pkg::REG_MAP_COLS:   prdata = {25'd0, map_columns};
      grcd_pkg::REG_MAP_ROWS:   prdata = {25'd0, map_rows_used};
      grcd_pkg::REG_MAX_DIST:   prdata = {12'd0, max_distance};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------- tile memory ----------------
  logic [7:0]    tile_mem [grcd_pkg::MAP_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          wr_in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= in_ch.tile_value & grcd_pkg::TILE_MASK;
    end
    if (mem_re) begin
      mem_rdata <= tile_mem[mem_raddr];
    end
  end

  // ---------------- engine registers ----------------
  state_t      state;
  div_tgt_t    div_tgt;
  logic [19:0] sx, sy, adx, ady;
  logic        negx, negy;
  logic [40:0] sq_x, sq_y;
  logic [57:0] rt_v, rt_r, rt_bit;
  logic [28:0] len;
  logic [51:0] div_dvd;
  logic [28:0] div_rem, div_sor;
  logic [5:0]  div_cnt;
  logic [23:0] step_x, step_y, edge_x, edge_y, walk_total;
  logic [20:0] cell_x, cell_y;
  logic        side, hit;
  logic [7:0]  tile_val;
  logic [43:0] prod;
  logic [19:0] res_hx, res_hy;
  logic        out_valid;
  logic        out_hit, out_side;
  logic [7:0]  out_tile;
  logic [19:0] out_dist, out_hx, out_hy;

  logic        in_acc, out_free, res_load;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign res_load    = (state == S_DONE) && out_free;

  assign out_ch.valid        = out_valid;
  assign out_ch.hit          = out_hit;
  assign out_ch.hit_side     = out_side;
  assign out_ch.hit_tile     = out_tile;
  assign out_ch.ray_distance = out_dist;
  assign out_ch.hit_x        = out_hx;
  assign out_ch.hit_y        = out_hy;

  // ---------------- combinational helpers ----------------
  logic [20:0] dx_s, dy_s;
  logic [57:0] rt_t;
  logic        rt_ge;
  logic [29:0] div_sh;
  logic        div_ge;
  logic [51:0] div_q;
  logic [8:0]  part_x, part_y;
  logic [32:0] ex_prod, ey_prod;
  logic        take_x;
  logic [24:0] sum_x, sum_y;
  logic [19:0] tx, ty;
  logic [7:0]  cols, rows;
  logic        in_bounds;
  logic [19:0] plc_start;
  logic        plc_neg;
  logic [20:0] plc_sum;
  logic [19:0] plc_res;

  assign mem_we    = in_acc && (in_ch.mode == grcd_pkg::MODE_WRITE) && wr_in_range;
  assign wr_in_range = (32'(in_ch.tile_col) < grcd_pkg::MAP_DIM) &&
                       (32'(in_ch.tile_row) < grcd_pkg::MAP_DIM);
  assign mem_waddr = AW'(32'(in_ch.tile_row) * grcd_pkg::MAP_DIM + 32'(in_ch.tile_col));
  assign mem_re    = (state == S_WALK_PROBE) && in_bounds;
  assign mem_raddr = AW'(32'(ty) * grcd_pkg::MAP_DIM + 32'(tx));

  always_comb begin
    dx_s = {1'b0, in_ch.target_x} - {1'b0, in_ch.start_x};
    dy_s = {1'b0, in_ch.target_y} - {1'b0, in_ch.start_y};

    rt_t  = rt_r + rt_bit;
    rt_ge = rt_v >= rt_t;

    div_sh = {div_rem, div_dvd[51]};
    div_ge = div_sh >= {1'b0, div_sor};
    div_q  = {div_dvd[50:0], div_ge};

    part_x  = negx ? {1'b0, sx[7:0]} : 9'd256 - {1'b0, sx[7:0]};
    part_y  = negy ? {1'b0, sy[7:0]} : 9'd256 - {1'b0, sy[7:0]};
    ex_prod = 33'(part_x) * 33'(step_x);
    ey_prod = 33'(part_y) * 33'(step_y);

    take_x = edge_x < edge_y;
    sum_x  = {1'b0, edge_x} + {1'b0, step_x};
    sum_y  = {1'b0, edge_y} + {1'b0, step_y};

    // cell to tile; negative cells are outside the map
    tx   = cell_x[19:0] >> tile_shift;
    ty   = cell_y[19:0] >> tile_shift;
    cols = (32'(map_columns) < grcd_pkg::MAP_DIM) ? {1'b0, map_columns}
                                                  : 8'(grcd_pkg::MAP_DIM);
    rows = (32'(map_rows_used) < grcd_pkg::MAP_DIM) ? {1'b0, map_rows_used}
                                                    : 8'(grcd_pkg::MAP_DIM);
    in_bounds = !cell_x[20] && !cell_y[20] && (tx < 20'(cols)) && (ty < 20'(rows));

    // collision point from the divider quotient, clamped to 0..MAX20
    plc_start = (div_tgt == DT_PX) ? sx : sy;
    plc_neg   = (div_tgt == DT_PX) ? negx : negy;
    plc_sum   = {1'b0, plc_start} + {1'b0, div_q[19:0]};
    if (plc_neg) begin
      plc_res = (div_q > 52'(plc_start)) ? 20'd0 : plc_start - div_q[19:0];
    end else if (div_q[51:20] != '0 || plc_sum[20]) begin
      plc_res = grcd_pkg::MAX20;
    end else begin
      plc_res = plc_sum[19:0];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_tgt   <= DT_SX;
      div_cnt   <= '0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && in_ch.mode == grcd_pkg::MODE_CAST) begin
            sx         <= in_ch.start_x;
            sy         <= in_ch.start_y;
            negx       <= dx_s[20];
            negy       <= dy_s[20];
            adx        <= dx_s[20] ? 20'(-dx_s) : dx_s[19:0];
            ady        <= dy_s[20] ? 20'(-dy_s) : dy_s[19:0];
            walk_total <= '0;
            hit        <= 1'b0;
            side       <= 1'b0;
            tile_val   <= '0;
            if (dx_s == '0 && dy_s == '0) state <= S_DONE;
            else state <= S_SQ_X;
          end
        end
        S_SQ_X: begin
          sq_x  <= 41'(adx) * 41'(adx);
          state <= S_SQ_Y;
        end
        S_SQ_Y: begin
          sq_y  <= 41'(ady) * 41'(ady);
          state <= S_ROOT_INIT;
        end
        S_ROOT_INIT: begin
          rt_v   <= {1'b0, sq_x + sq_y, 16'd0};
          rt_r   <= '0;
          rt_bit <= 58'd1 << 56;
          state  <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle
          if (rt_ge) begin
            rt_v <= rt_v - rt_t;
            rt_r <= (rt_r >> 1) + rt_bit;
          end else begin
            rt_r <= rt_r >> 1;
          end
          rt_bit <= rt_bit >> 2;
          if (rt_bit[0]) begin
            len   <= rt_ge ? 29'((rt_r >> 1) + rt_bit) : 29'(rt_r >> 1);
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (adx == '0) begin
            step_x <= grcd_pkg::MAX24;
            state  <= S_DIVY;
          end else begin
            div_dvd <= 52'(len);
            div_sor <= 29'(adx);
            div_rem <= '0;
            div_cnt <= 6'd52;
            div_tgt <= DT_SX;
            state   <= S_DIV;
          end
        end
        S_DIVY: begin
          if (ady == '0) begin
            step_y <= grcd_pkg::MAX24;
            state  <= S_EDGE;
          end else begin
            div_dvd <= 52'(len);
            div_sor <= 29'(ady);
            div_rem <= '0;
            div_cnt <= 6'd52;
            div_tgt <= DT_SY;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          div_rem <= div_ge ? 29'(div_sh - {1'b0, div_sor}) : div_sh[28:0];
          div_dvd <= div_q;
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            case (div_tgt)
              DT_SX: begin
                step_x <= (div_q[51:24] != '0) ? grcd_pkg::MAX24 : div_q[23:0];
                state  <= S_DIVY;
              end
              DT_SY: begin
                step_y <= (div_q[51:24] != '0) ? grcd_pkg::MAX24 : div_q[23:0];
                state  <= S_EDGE;
              end
              DT_PX: begin
                res_hx <= plc_res;
                state  <= S_PY_MUL;
              end
              DT_PY: begin
                res_hy <= plc_res;
                state  <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EDGE: begin
          edge_x <= ex_prod[32] ? grcd_pkg::MAX24 : ex_prod[31:8];
          edge_y <= ey_prod[32] ? grcd_pkg::MAX24 : ey_prod[31:8];
          cell_x <= {9'd0, sx[19:8]};
          cell_y <= {9'd0, sy[19:8]};
          state  <= S_WALK_TEST;
        end
        S_WALK_TEST: begin
          state <= (walk_total < 24'(max_distance)) ? S_WALK_STEP : S_DONE;
        end
        S_WALK_STEP: begin
          if (take_x) begin
            cell_x     <= negx ? cell_x - 21'd1 : cell_x + 21'd1;
            walk_total <= edge_x;
            edge_x     <= sum_x[24] ? grcd_pkg::MAX24 : sum_x[23:0];
            side       <= 1'b0;
          end else begin
            cell_y     <= negy ? cell_y - 21'd1 : cell_y + 21'd1;
            walk_total <= edge_y;
            edge_y     <= sum_y[24] ? grcd_pkg::MAX24 : sum_y[23:0];
            side       <= 1'b1;
          end
          state <= S_WALK_PROBE;
        end
        S_WALK_PROBE: begin
          state <= in_bounds ? S_WALK_CHECK : S_WALK_TEST;
        end
        S_WALK_CHECK: begin
          if (mem_rdata != '0) begin
            hit      <= 1'b1;
            tile_val <= mem_rdata;
            state    <= S_PX_MUL;
          end else begin
            state <= S_WALK_TEST;
          end
        end
        S_PX_MUL: begin
          prod  <= 44'(adx) * 44'(walk_total);
          state <= S_PX_DIV;
        end
        S_PX_DIV: begin
          div_dvd <= {prod, 8'd0};
          div_sor <= len;
          div_rem <= '0;
          div_cnt <= 6'd52;
          div_tgt <= DT_PX;
          state   <= S_DIV;
        end
        S_PY_MUL: begin
          prod  <= 44'(ady) * 44'(walk_total);
          state <= S_PY_DIV;
        end
        S_PY_DIV: begin
          div_dvd <= {prod, 8'd0};
          div_sor <= len;
          div_rem <= '0;
          div_cnt <= 6'd52;
          div_tgt <= DT_PY;
          state   <= S_DIV;
        end
        S_DONE: begin
          if (out_free) begin
            out_hit   <= hit;
            out_side  <= hit && side;
            out_tile  <= hit ? tile_val : 8'd0;
            out_dist  <= (walk_total[23:20] != '0) ? grcd_pkg::MAX20 : walk_total[19:0];
            out_hx    <= hit ? res_hx : 20'd0;
            out_hy    <= hit ? res_hy : 20'd0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GRCD_ASSERT_NXT(a_cast_leaves_idle, in_acc && in_ch.mode == grcd_pkg::MODE_CAST,
                   state != S_IDLE)
  `GRCD_ASSERT_IMP(a_load_when_free, res_load, !out_valid || out_ch.ready)
  `GRCD_ASSERT_NXT(a_step_then_probe, state == S_WALK_STEP, state == S_WALK_PROBE)
  `GRCD_ASSERT_IMP(a_read_in_walk, mem_re, state == S_WALK_PROBE && !cell_x[20])
endmodule
